// ===== design/gradient_noise_2d_macros.svh =====
// Assertion macros for the gradient noise block.
// Used by the top level only; no other dependencies.
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH

// Check a property on a given clock, disabled while reset is low.
`define GN2_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define GN2_ASSERT(label, prop, msg) \
  `GN2_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/gn2_pkg.sv =====
// Package for the gradient noise block: grid and fixed-point constants, op codes.
// No dependencies.
`timescale 1ns / 1ps

package gn2_pkg;

  localparam int GRID_X    = 128;
  localparam int GRID_Y    = 128;
  localparam int FRAC_BITS = 16;

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int AW    = XW + YW;
  localparam int DEPTH = GRID_X * GRID_Y;

  localparam int CELL_W  = 7;
  localparam int POS_W   = 23;
  localparam int GRAD_W  = 16;
  localparam int NOISE_W = 18;

  localparam int NOISE_MAX = 131071;
  localparam int NOISE_MIN = -131072;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

endpackage

// ===== design/gn2_if.sv =====
// Handshake channels of the gradient noise block: input items and noise results.
// Depends on gn2_pkg.
`timescale 1ns / 1ps

interface gn2_in_if;
  import gn2_pkg::*;
  logic                valid;
  logic                ready;
  op_e                 op;
  logic [CELL_W-1:0]   cell_x;
  logic [CELL_W-1:0]   cell_y;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;

  modport source (output valid, op, cell_x, cell_y, grad_x, grad_y, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, op, cell_x, cell_y, grad_x, grad_y, pos_x, pos_y,
                  output ready);
endinterface

interface gn2_out_if;
  import gn2_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise;

  modport source (output valid, noise, input ready);
  modport sink   (input valid, noise, output ready);
endinterface

// ===== design/gradient_noise_2d.sv =====
// Channel | Dir | Payload                                   | Transaction
// in_i    | in  | op, cell_x, cell_y, grad_x/y, pos_x/y     | valid & ready
// out_o   | out | noise (Q2.16, one per evaluate item)      | valid & ready
//
// One item per cycle while out_o is not held; an evaluate result is registered by the
// table read on its transaction edge, then by corner dots, ease, x blend, and
// y blend + saturate, each in its own stage, before it is valid on out_o.
// Four corner reads per cycle come from two table copies, each with two read ports.
// Reset clears pipeline valid bits only; table entries are undefined until written.
// A held result freezes the whole pipeline and drops in_i.ready in that cycle.
// Depends on gn2_pkg, gn2_if and gradient_noise_2d_macros.svh.
`timescale 1ns / 1ps

`include "gradient_noise_2d_macros.svh"

module gradient_noise_2d (
  input  logic      clk_i,
  input  logic      rst_ni,
  gn2_in_if.sink    in_i,
  gn2_out_if.source out_o
);
  import gn2_pkg::*;

  localparam int ONE   = 1 << FRAC_BITS;
  localparam int D_W   = FRAC_BITS + 2;
  localparam int PD_W  = GRAD_W + D_W + 1;
  localparam int DOT_W = FRAC_BITS + 5;
  localparam int S_W   = FRAC_BITS + 2;
  localparam int IX_W  = DOT_W + 2;
  localparam int BP_W  = IX_W + S_W + 2;
  localparam int SQ_W  = 2 * FRAC_BITS + 1;
  localparam int EP_W  = 2 * FRAC_BITS + 3;

  // Dot product of a packed gradient with an offset, rounded back to Q.F.
  function automatic logic signed [DOT_W-1:0] dot_f(logic [2*GRAD_W-1:0] e,
                                                   logic signed [D_W-1:0] dx,
                                                   logic signed [D_W-1:0] dy);
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [PD_W-1:0]   p;
    gx = e[2*GRAD_W-1:GRAD_W];
    gy = e[GRAD_W-1:0];
    p  = PD_W'(gx) * PD_W'(dx) + PD_W'(gy) * PD_W'(dy) + PD_W'(1 << 13);
    return DOT_W'(p >>> 14);
  endfunction

  // lo + round((hi - lo) * s / 2^F)
  function automatic logic signed [IX_W-1:0] blend_f(logic signed [IX_W-1:0] lo,
                                                     logic signed [IX_W-1:0] hi,
                                                     logic [S_W-1:0] s);
    logic signed [IX_W:0]   diff;
    logic signed [S_W:0]    ss;
    logic signed [BP_W-1:0] p;
    diff = (IX_W+1)'(hi) - (IX_W+1)'(lo);
    ss   = $signed({1'b0, s});
    p    = BP_W'(diff) * BP_W'(ss) + BP_W'(ONE / 2);
    return IX_W'(lo + IX_W'(p >>> FRAC_BITS));
  endfunction

  // Stage 0: transaction, table write, corner addresses
  logic          adv;
  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [2*GRAD_W-1:0] wdata;
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;

  assign adv         = !out_o.valid || out_o.ready;
  assign in_i.ready  = adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign wr_en       = in_acc && (in_i.op == OP_WRITE);
  assign waddr       = {in_i.cell_y[YW-1:0], in_i.cell_x[XW-1:0]};
  assign wdata       = {in_i.grad_x, in_i.grad_y};
  assign x0          = in_i.pos_x[FRAC_BITS +: XW];
  assign y0          = in_i.pos_y[FRAC_BITS +: YW];
  assign x1          = XW'(x0 + 1'b1);
  assign y1          = YW'(y0 + 1'b1);

  // Two copies of the gradient table; both take every write. A write and a
  // later read of the same entry land on different edges, so no forwarding.
  logic [2*GRAD_W-1:0] mem_a_q [0:DEPTH-1];
  logic [2*GRAD_W-1:0] mem_b_q [0:DEPTH-1];
  logic [2*GRAD_W-1:0] rd00_q, rd10_q, rd01_q, rd11_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_a_q[waddr] <= wdata;
    if (adv) begin
      rd00_q <= mem_a_q[{y0, x0}];
      rd10_q <= mem_a_q[{y0, x1}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_b_q[waddr] <= wdata;
    if (adv) begin
      rd01_q <= mem_b_q[{y1, x0}];
      rd11_q <= mem_b_q[{y1, x1}];
    end
  end

  logic v1_q, v2_q, v3_q, v4_q, vout_q;
  logic [FRAC_BITS-1:0] fx1_q, fy1_q, fx2_q, fy2_q;

  // Stage 1: corner dot products, t squared
  logic signed [D_W-1:0] dx0, dx1, dy0, dy1;
  logic [SQ_W-1:0] sqx, sqy;
  logic signed [DOT_W-1:0] n00_q, n10_q, n01_q, n11_q;
  logic [FRAC_BITS:0] t2x_q, t2y_q;

  assign dx0 = $signed({2'b00, fx1_q});
  assign dy0 = $signed({2'b00, fy1_q});
  assign dx1 = dx0 - D_W'(ONE);
  assign dy1 = dy0 - D_W'(ONE);
  assign sqx = SQ_W'(fx1_q) * SQ_W'(fx1_q) + SQ_W'(ONE / 2);
  assign sqy = SQ_W'(fy1_q) * SQ_W'(fy1_q) + SQ_W'(ONE / 2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx1_q <= in_i.pos_x[FRAC_BITS-1:0];
      fy1_q <= in_i.pos_y[FRAC_BITS-1:0];
      n00_q <= dot_f(rd00_q, dx0, dy0);
      n10_q <= dot_f(rd10_q, dx1, dy0);
      n01_q <= dot_f(rd01_q, dx0, dy1);
      n11_q <= dot_f(rd11_q, dx1, dy1);
      t2x_q <= sqx[SQ_W-1:FRAC_BITS];
      t2y_q <= sqy[SQ_W-1:FRAC_BITS];
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
    end
  end

  // Stage 2: finish smoothstep, s = round(t2 * (3 - 2t))
  logic [FRAC_BITS+1:0] kx, ky;
  logic [EP_W-1:0] epx, epy;
  logic [S_W-1:0] sx_q, sy_q, sy4_q;
  logic signed [DOT_W-1:0] m00_q, m10_q, m01_q, m11_q;

  assign kx  = (FRAC_BITS+2)'(3 * ONE) - (FRAC_BITS+2)'({fx2_q, 1'b0});
  assign ky  = (FRAC_BITS+2)'(3 * ONE) - (FRAC_BITS+2)'({fy2_q, 1'b0});
  assign epx = EP_W'(t2x_q) * EP_W'(kx) + EP_W'(ONE / 2);
  assign epy = EP_W'(t2y_q) * EP_W'(ky) + EP_W'(ONE / 2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q  <= epx[FRAC_BITS +: S_W];
      sy_q  <= epy[FRAC_BITS +: S_W];
      m00_q <= n00_q;
      m10_q <= n10_q;
      m01_q <= n01_q;
      m11_q <= n11_q;
    end
  end

  // Stage 3: blend along x
  logic signed [IX_W-1:0] ix0_q, ix1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ix0_q <= blend_f(IX_W'(m00_q), IX_W'(m10_q), sx_q);
      ix1_q <= blend_f(IX_W'(m01_q), IX_W'(m11_q), sx_q);
      sy4_q <= sy_q;
    end
  end

  // Stage 4: blend along y, saturate (Q.F equals the Q2.16 output scale)
  logic signed [IX_W-1:0]    vy;
  logic signed [NOISE_W-1:0] sat_d, noise_q;

  assign vy = blend_f(ix0_q, ix1_q, sy4_q);

  always_comb begin
    if (vy > IX_W'(NOISE_MAX))      sat_d = NOISE_W'(NOISE_MAX);
    else if (vy < IX_W'(NOISE_MIN)) sat_d = NOISE_W'(NOISE_MIN);
    else                            sat_d = NOISE_W'(vy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) noise_q <= sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (adv) begin
      v1_q   <= in_acc && (in_i.op == OP_EVAL);
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      vout_q <= v4_q;
    end
  end

  assign out_o.valid = vout_q;
  assign out_o.noise = noise_q;

  `GN2_ASSERT(a_write_no_result, (in_acc && in_i.op == OP_WRITE) |=> !v1_q, "write made a result")
  `GN2_ASSERT(a_stall_holds, !adv |=> $stable({v1_q, v2_q, v3_q, v4_q, noise_q}), "stall lost data")
  `GN2_ASSERT(a_advance, (adv && v4_q) |=> vout_q, "result dropped at output")

endmodule

// ===== test/gradient_noise_2d_tb.sv =====
// Self-checking testbench for gradient_noise_2d: gradient writes and noise evaluations.
// Depends on gn2_pkg, gn2_if and the gradient_noise_2d RTL.
`timescale 1ns / 1ps

module gradient_noise_2d_tb;
  import gn2_pkg::*;

  typedef struct {
    op_e                 op;
    logic [CELL_W-1:0]   cx;
    logic [CELL_W-1:0]   cy;
    logic [GRAD_W-1:0]   gx;
    logic [GRAD_W-1:0]   gy;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    bit                  known;
    logic [NOISE_W-1:0]  want;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  gn2_in_if  in_ch ();
  gn2_out_if out_ch ();

  gradient_noise_2d dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  logic [31:0] grad_mem [DEPTH];
  bit          grad_set [DEPTH];
  logic [NOISE_W-1:0] noise_q [$];
  int  mismatches = 0;
  bit  calm = 0;
  item_t dir_rows [$];

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint corner(int ix, int iy, longint dx, longint dy);
    logic [31:0] e;
    longint gx, gy;
    e = grad_mem[(iy % GRID_Y) * GRID_X + (ix % GRID_X)];
    gx = longint'($signed(e[31:16]));
    gy = longint'($signed(e[15:0]));
    return rshift_round(gx * dx + gy * dy, 14);
  endfunction

  function automatic longint smooth(longint t);
    longint t2;
    t2 = rshift_round(t * t, FRAC_BITS);
    return rshift_round(t2 * (3 * (longint'(1) << FRAC_BITS) - 2 * t), FRAC_BITS);
  endfunction

  function automatic longint mix(longint lo, longint hi, longint s);
    return lo + rshift_round((hi - lo) * s, FRAC_BITS);
  endfunction

  function automatic logic [NOISE_W-1:0] noise_at(logic [POS_W-1:0] px,
                                                  logic [POS_W-1:0] py);
    longint one, fx, fy, n00, n10, n01, n11, sx, sy, v;
    int x0, y0, x1, y1;
    one = longint'(1) << FRAC_BITS;
    x0 = (px >> FRAC_BITS) % GRID_X;
    y0 = (py >> FRAC_BITS) % GRID_Y;
    x1 = (x0 + 1) % GRID_X;
    y1 = (y0 + 1) % GRID_Y;
    fx = px & (one - 1);
    fy = py & (one - 1);
    n00 = corner(x0, y0, fx, fy);
    n10 = corner(x1, y0, fx - one, fy);
    n01 = corner(x0, y1, fx, fy - one);
    n11 = corner(x1, y1, fx - one, fy - one);
    sx = smooth(fx);
    sy = smooth(fy);
    v = mix(mix(n00, n10, sx), mix(n01, n11, sx), sy);
    if (FRAC_BITS > 16) v = rshift_round(v, FRAC_BITS - 16);
    else v = v * (longint'(1) << (16 - FRAC_BITS));
    if (v > NOISE_MAX) v = NOISE_MAX;
    if (v < NOISE_MIN) v = NOISE_MIN;
    return v[NOISE_W-1:0];
  endfunction

  // all four corners around the position must hold a written gradient
  function automatic bit corners_set(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    int x0, y0, x1, y1;
    x0 = (px >> FRAC_BITS) % GRID_X;
    y0 = (py >> FRAC_BITS) % GRID_Y;
    x1 = (x0 + 1) % GRID_X;
    y1 = (y0 + 1) % GRID_Y;
    return grad_set[y0*GRID_X+x0] && grad_set[y0*GRID_X+x1] &&
           grad_set[y1*GRID_X+x0] && grad_set[y1*GRID_X+x1];
  endfunction

  // drive one transaction; valid stays high on return so items can follow
  task automatic send(item_t it);
    logic [NOISE_W-1:0] n;
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= it.op;
    in_ch.cell_x <= it.cx;
    in_ch.cell_y <= it.cy;
    in_ch.grad_x <= it.gx;
    in_ch.grad_y <= it.gy;
    in_ch.pos_x  <= it.px;
    in_ch.pos_y  <= it.py;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.op == OP_WRITE) begin
      grad_mem[it.cy*GRID_X + it.cx] = {it.gx, it.gy};
      grad_set[it.cy*GRID_X + it.cx] = 1'b1;
    end else begin
      n = noise_at(it.px, it.py);
      if (it.known && n != it.want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("predictor disagrees with table row: want %0d got %0d",
                   $signed(it.want), $signed(n));
      end
      noise_q.push_back(n);
    end
    @(negedge clk_i);
  endtask

  function automatic item_t wr(int cx, int cy, int gx, int gy);
    item_t it;
    it = '{OP_WRITE, CELL_W'(cx), CELL_W'(cy), GRAD_W'(gx), GRAD_W'(gy),
           POS_W'($urandom), POS_W'($urandom), 1'b0, '0};
    return it;
  endfunction

  function automatic item_t ev(int px, int py, bit known = 0, int want = 0);
    item_t it;
    it = '{OP_EVAL, CELL_W'($urandom), CELL_W'($urandom), GRAD_W'($urandom),
           GRAD_W'($urandom), POS_W'(px), POS_W'(py), known, NOISE_W'(want)};
    return it;
  endfunction

  // result side: random stall, compare against oldest prediction
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (noise_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected noise transaction %0d", out_ch.noise);
      end else begin
        logic [NOISE_W-1:0] w;
        w = noise_q.pop_front();
        if (out_ch.noise !== w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d actual %0d", $signed(w),
                     $signed(out_ch.noise));
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int k, r, c, a;
    in_ch.valid = 1'b0; in_ch.op = OP_WRITE; in_ch.cell_x = '0; in_ch.cell_y = '0;
    in_ch.grad_x = '0; in_ch.grad_y = '0; in_ch.pos_x = '0; in_ch.pos_y = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: corners of the grid, extreme gradients, wrap at the edge
    dir_rows.push_back(wr(0, 0, 16384, 0));
    dir_rows.push_back(wr(1, 0, 16384, 0));
    dir_rows.push_back(wr(0, 1, 16384, 0));
    dir_rows.push_back(wr(1, 1, 16384, 0));
    dir_rows.push_back(ev(0, 0, 1, 0));             // lattice point: offsets zero
    dir_rows.push_back(ev(32'h8000, 32'h8000));
    dir_rows.push_back(wr(127, 127, -16384, 0));
    dir_rows.push_back(wr(0, 127, 0, 16384));
    dir_rows.push_back(wr(127, 0, 0, -16384));
    dir_rows.push_back(ev(127 << 16, 127 << 16, 1, 0));
    dir_rows.push_back(ev(23'h7FFFFF, 23'h7FFFFF));  // both neighbors wrap to zero
    dir_rows.push_back(wr(127, 1, 0, 16384));
    dir_rows.push_back(ev((127 << 16) | 1, 1));
    dir_rows.push_back(wr(0, 0, 32767, 32767));      // oversize gradient components
    dir_rows.push_back(wr(1, 0, -32768, -32768));
    dir_rows.push_back(ev(32'hFFFF, 32'h0001));
    dir_rows.push_back(ev(32'h7FFF, 32'hFFFF));
    dir_rows.push_back(wr(1, 1, 32767, -32768));
    dir_rows.push_back(wr(0, 1, -32768, 32767));
    dir_rows.push_back(ev(32'hC000, 32'hC000));
    dir_rows.push_back(ev(32'h4000, 32'hFFFF));
    foreach (dir_rows[i]) send(dir_rows[i]);

    // fill a patch so random evaluations have written corners; fill also wraps
    for (r = 0; r < 6; r++)
      for (c = 0; c < 6; c++) begin
        a = $urandom_range(3);
        send(wr(c < 5 ? c : 127, r < 5 ? r : 127,
                a[0] ? 11585 : -11585, a[1] ? 11585 : -11585));
      end

    for (k = 0; k < 560; k++) begin
      item_t it;
      calm = (k >= 200 && k < 300);
      if (k == 400) begin
        // hold the sender until every prediction has been met
        in_ch.valid <= 1'b0;
        while (noise_q.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(3) == 0) begin
        it = wr($urandom_range(127), $urandom_range(127), $urandom, $urandom);
        if ($urandom_range(1)) it = wr($urandom_range(4), $urandom_range(4),
                                       $urandom_range(32768) - 16384,
                                       $urandom_range(32768) - 16384);
      end else begin
        it = ev($urandom, $urandom);
        while (!corners_set(it.px, it.py)) begin
          it.px = {$urandom_range(1) ? 7'd127 : 7'($urandom_range(4)), 16'($urandom)};
          it.py = {$urandom_range(1) ? 7'd127 : 7'($urandom_range(4)), 16'($urandom)};
        end
      end
      send(it);
    end
    calm = 0;
    in_ch.valid <= 1'b0;

    while (noise_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && noise_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
